>>> hw/rtl/rau_pkg.sv
// shared types and constants for the rational arithmetic unit
package rau_pkg;

    typedef enum logic [2:0] {
        OP_REDUCE = 3'd0,
        OP_ADD    = 3'd1,
        OP_SUB    = 3'd2,
        OP_MUL    = 3'd3,
        OP_DIV    = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_DIV_ZERO = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic combine;
        logic gcd_start;
        logic div_start;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic err;
        logic zero_num;
        logic gcd_done;
        logic div_done;
    } sts_t;

endpackage

>>> hw/rtl/rational_arith_unit.sv
// top level of the rational arithmetic unit
//
// input channel: in_valid/in_stall with operation, a_num, a_den, b_num, b_den;
// a transfer happens when in_valid is high and in_stall is low
// output channel: out_valid/out_stall with res_num, res_den, status
// each operation yields exactly one result transfer, fractions reduced to
// lowest terms with a positive denominator and the sign on the numerator
// errors and zero results skip the gcd and divide; otherwise each gcd
// remainder step runs on the shared bit-serial divider, followed by two
// final quotients on the same divider
// one item is in flight at a time; the next input transfer is taken in the
// same cycle the previous result is taken
// while out_stall is high the result holds and no new input is taken
// reset clears the controller; no item is pending afterwards
module rational_arith_unit #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  operation,
    input  logic [31:0] a_num,
    input  logic [31:0] a_den,
    input  logic [31:0] b_num,
    input  logic [31:0] b_den,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] res_num,
    output logic [30:0] res_den,
    output logic [1:0]  status
);
    rau_pkg::cmd_t cmd;
    rau_pkg::sts_t sts;

    rau_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    rau_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .operation (operation),
        .a_num     (a_num),
        .a_den     (a_den),
        .b_num     (b_num),
        .b_den     (b_den),
        .res_num   (res_num),
        .res_den   (res_den),
        .status    (status)
    );

endmodule

>>> hw/rtl/rau_datapath.sv
// datapath: operand split, cross products, bit-serial remainder gcd and divide
module rau_datapath #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rau_pkg::cmd_t      cmd,
    output rau_pkg::sts_t      sts,
    input  logic [2:0]         operation,
    input  logic [31:0]        a_num,
    input  logic [31:0]        a_den,
    input  logic [31:0]        b_num,
    input  logic [31:0]        b_den,
    output logic [31:0]        res_num,
    output logic [30:0]        res_den,
    output logic [1:0]         status
);
    localparam int VW = VALUE_WIDTH;
    localparam int DW = 2 * VALUE_WIDTH;
    localparam int CW = $clog2(DW + 1);

    logic [VW-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic          san_reg, sad_reg, sbn_reg, sbd_reg;
    rau_pkg::op_t  op_reg;
    logic [1:0]    err_reg;
    logic [DW-1:0] p1_reg, p2_reg, n_reg, d_reg;
    logic          neg_reg;

    // gcd / divide registers
    logic [DW-1:0] y_reg, rem_reg, dvd_reg;
    logic          busy_reg, gcd_mode_reg, gcd_done_reg, div_done_reg;
    logic          div_phase_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] g_reg;
    logic          quo_n_wr, quo_d_wr;

    logic [VW-1:0] fa_num, fa_den, fb_num, fb_den;
    logic [VW-1:0] mag_an, mag_ad, mag_bn, mag_bd;
    rau_pkg::op_t  op_dec;

    assign fa_num = a_num[VW-1:0];
    assign fa_den = a_den[VW-1:0];
    assign fb_num = b_num[VW-1:0];
    assign fb_den = b_den[VW-1:0];
    assign mag_an = fa_num[VW-1] ? (~fa_num + 1'b1) : fa_num;
    assign mag_ad = fa_den[VW-1] ? (~fa_den + 1'b1) : fa_den;
    assign mag_bn = fb_num[VW-1] ? (~fb_num + 1'b1) : fb_num;
    assign mag_bd = fb_den[VW-1] ? (~fb_den + 1'b1) : fb_den;

    always_comb
    begin
        unique case (operation)
            3'd1:    op_dec = rau_pkg::OP_ADD;
            3'd2:    op_dec = rau_pkg::OP_SUB;
            3'd3:    op_dec = rau_pkg::OP_MUL;
            3'd4:    op_dec = rau_pkg::OP_DIV;
            default: op_dec = rau_pkg::OP_REDUCE;
        endcase
    end

    // note: a magnitude of the minimum value is 2^(VW-1), which fits unsigned VW bits
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            an_reg  <= mag_an;
            ad_reg  <= mag_ad;
            bn_reg  <= mag_bn;
            bd_reg  <= mag_bd;
            san_reg <= fa_num[VW-1];
            sad_reg <= fa_den[VW-1];
            sbn_reg <= fb_num[VW-1];
            sbd_reg <= fb_den[VW-1];
            op_reg  <= op_dec;
            if (mag_ad == '0 || (op_dec != rau_pkg::OP_REDUCE && mag_bd == '0))
                err_reg <= rau_pkg::ST_ZERO_DEN;
            else if (op_dec == rau_pkg::OP_DIV && mag_bn == '0)
                err_reg <= rau_pkg::ST_DIV_ZERO;
            else
                err_reg <= rau_pkg::ST_OK;
        end
        if (cmd.mul1)
        begin
            unique case (op_reg)
                rau_pkg::OP_REDUCE: p1_reg <= {{VW{1'b0}}, an_reg};
                rau_pkg::OP_MUL:    p1_reg <= an_reg * bn_reg;
                default:            p1_reg <= an_reg * bd_reg;
            endcase
        end
        if (cmd.mul2)
        begin
            unique case (op_reg)
                rau_pkg::OP_REDUCE: p2_reg <= {{VW{1'b0}}, ad_reg};
                rau_pkg::OP_DIV:    p2_reg <= ad_reg * bn_reg;
                rau_pkg::OP_MUL:    p2_reg <= ad_reg * bd_reg;
                default:            p2_reg <= bn_reg * ad_reg;
            endcase
        end
    end

    logic s1, s2;
    assign s1 = san_reg ^ sbd_reg;
    assign s2 = (sbn_reg ^ sad_reg) ^ (op_reg == rau_pkg::OP_SUB);

    // final quotients land back in n_reg and d_reg
    assign quo_n_wr = busy_reg && (cnt_reg == '0) && !gcd_mode_reg && !div_phase_reg
                      && !cmd.gcd_start && !cmd.div_start;
    assign quo_d_wr = busy_reg && (cnt_reg == '0) && !gcd_mode_reg && div_phase_reg
                      && !cmd.gcd_start && !cmd.div_start;

    // combine step; add/sub keep d_reg, others take p2
    always_ff @(posedge clk)
    begin
        // denominator for add/sub goes to d_reg separately
        if (cmd.mul2)
            d_reg <= ad_reg * bd_reg;
        if (cmd.combine)
        begin
            unique case (op_reg)
                rau_pkg::OP_ADD, rau_pkg::OP_SUB:
                begin
                    if (s1 == s2)
                    begin
                        n_reg   <= p1_reg + p2_reg;
                        neg_reg <= s1 ^ (sad_reg ^ sbd_reg);
                    end
                    else if (p1_reg >= p2_reg)
                    begin
                        n_reg   <= p1_reg - p2_reg;
                        neg_reg <= s1 ^ (sad_reg ^ sbd_reg);
                    end
                    else
                    begin
                        n_reg   <= p2_reg - p1_reg;
                        neg_reg <= s2 ^ (sad_reg ^ sbd_reg);
                    end
                end
                rau_pkg::OP_REDUCE:
                begin
                    n_reg   <= p1_reg;
                    d_reg   <= p2_reg;
                    neg_reg <= san_reg ^ sad_reg;
                end
                rau_pkg::OP_MUL:
                begin
                    n_reg   <= p1_reg;
                    d_reg   <= p2_reg;
                    neg_reg <= (san_reg ^ sbn_reg) ^ (sad_reg ^ sbd_reg);
                end
                default:
                begin
                    n_reg   <= p1_reg;
                    d_reg   <= p2_reg;
                    neg_reg <= (san_reg ^ sbd_reg) ^ (sad_reg ^ sbn_reg);
                end
            endcase
        end
        if (quo_n_wr)
            n_reg <= dvd_reg;
        if (quo_d_wr)
            d_reg <= dvd_reg;
    end

    // shared restoring divider: used for gcd remainders and the final quotients
    logic [DW:0]   trial;
    logic [DW-1:0] rem_shift;
    assign rem_shift = {rem_reg[DW-2:0], dvd_reg[DW-1]};
    assign trial     = {1'b0, rem_shift} - {1'b0, y_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.gcd_start)
        begin
            y_reg   <= d_reg;
            dvd_reg <= n_reg;
            rem_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            dvd_reg <= n_reg;
            y_reg   <= g_reg;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                if (!trial[DW])
                    rem_reg <= trial[DW-1:0];
                else
                    rem_reg <= rem_shift;
                dvd_reg <= {dvd_reg[DW-2:0], ~trial[DW]};
            end
            else if (gcd_mode_reg)
            begin
                // rem_reg = x mod y
                if (rem_reg == '0)
                    g_reg <= y_reg;
                else
                begin
                    y_reg   <= rem_reg;
                    dvd_reg <= y_reg;
                    rem_reg <= '0;
                end
            end
            else if (!div_phase_reg)
            begin
                dvd_reg <= d_reg;
                rem_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            gcd_mode_reg  <= 1'b0;
            gcd_done_reg  <= 1'b0;
            div_done_reg  <= 1'b0;
            div_phase_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            gcd_done_reg <= 1'b0;
            div_done_reg <= 1'b0;
            if (cmd.gcd_start)
            begin
                gcd_mode_reg <= 1'b1;
                busy_reg     <= 1'b1;
                cnt_reg      <= CW'(DW);
            end
            else if (cmd.div_start)
            begin
                gcd_mode_reg  <= 1'b0;
                busy_reg      <= 1'b1;
                div_phase_reg <= 1'b0;
                cnt_reg       <= CW'(DW);
            end
            else if (busy_reg)
            begin
                if (cnt_reg != '0)
                    cnt_reg <= cnt_reg - 1'b1;
                else if (gcd_mode_reg)
                begin
                    if (rem_reg == '0)
                    begin
                        busy_reg     <= 1'b0;
                        gcd_done_reg <= 1'b1;
                    end
                    else
                        cnt_reg <= CW'(DW);
                end
                else if (!div_phase_reg)
                begin
                    div_phase_reg <= 1'b1;
                    cnt_reg       <= CW'(DW);
                end
                else
                begin
                    busy_reg     <= 1'b0;
                    div_done_reg <= 1'b1;
                end
            end
        end
    end

    localparam logic [DW-1:0] SIGN_LIM = DW'(1) << (VW - 1);

    logic          ovf;
    logic [DW-1:0] signed_n;
    assign ovf = (d_reg > SIGN_LIM - 1'b1) || (n_reg > (neg_reg ? SIGN_LIM : SIGN_LIM - 1'b1));
    assign signed_n = neg_reg ? (~n_reg + 1'b1) : n_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            if (err_reg != rau_pkg::ST_OK)
            begin
                res_num <= '0;
                res_den <= '0;
                status  <= err_reg;
            end
            else if (n_reg == '0)
            begin
                res_num <= '0;
                res_den <= 31'd1;
                status  <= rau_pkg::ST_OK;
            end
            else if (ovf)
            begin
                res_num <= '0;
                res_den <= '0;
                status  <= rau_pkg::ST_OVERFLOW;
            end
            else
            begin
                res_num <= 32'(signed'(signed_n[VW-1:0]));
                res_den <= 31'(d_reg[VW-1:0]);
                status  <= rau_pkg::ST_OK;
            end
        end
    end

    assign sts.err      = (err_reg != rau_pkg::ST_OK);
    assign sts.zero_num = (n_reg == '0);
    assign sts.gcd_done = gcd_done_reg;
    assign sts.div_done = div_done_reg;

endmodule

>>> hw/rtl/rau_ctrl.sv
// controller: sequences load, products, gcd, divide and result transfer
module rau_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    output rau_pkg::cmd_t cmd,
    input  rau_pkg::sts_t sts
);
    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_COMB, S_CHECK, S_GCD, S_DIV, S_FIN, S_OUT
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;

    assign in_stall  = (state_reg != S_IDLE) && !(state_reg == S_OUT && !out_stall);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd = '0;
        cmd.load      = in_valid && !in_stall;
        cmd.mul1      = (state_reg == S_MUL1);
        cmd.mul2      = (state_reg == S_MUL2);
        cmd.combine   = (state_reg == S_COMB);
        cmd.gcd_start = (state_reg == S_CHECK) && !sts.err && !sts.zero_num;
        cmd.div_start = (state_reg == S_GCD) && sts.gcd_done;
        cmd.finish    = (state_reg == S_FIN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                    if (in_valid)
                        state_reg <= S_MUL1;
                S_MUL1:  state_reg <= S_MUL2;
                S_MUL2:  state_reg <= S_COMB;
                S_COMB:  state_reg <= S_CHECK;
                S_CHECK:
                    if (sts.err || sts.zero_num)
                        state_reg <= S_FIN;
                    else
                        state_reg <= S_GCD;
                S_GCD:
                    if (sts.gcd_done)
                        state_reg <= S_DIV;
                S_DIV:
                    if (sts.div_done)
                        state_reg <= S_FIN;
                S_FIN:
                begin
                    state_reg     <= S_OUT;
                    out_valid_reg <= 1'b1;
                end
                S_OUT:
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= in_valid ? S_MUL1 : S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
